// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, a, b)
`define ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/fbh_pkg.sv -----
// ----------------------------------------------------------------------------
// fbh_pkg
// shared constants and controller/datapath types of the histogram vote block
// ----------------------------------------------------------------------------
package fbh_pkg;

    localparam int DEF_BINS      = 16;
    localparam int DEF_BIN_WIDTH = 16;
    localparam int DEF_MAX_BATCH = 65535;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_RATE = 1'd1;
    localparam logic [15:0] FG_RATE_RST = 16'd6554;
    localparam logic [15:0] BG_RATE_RST = 16'd13107;

    localparam int PROB_W  = 32;
    localparam int SKILL_W = 40;
    localparam int DIV_W   = 64;
    localparam int QUO_W   = 32;
    localparam int STEP_W  = 6;

    localparam logic [16:0]        W_ONE     = 17'h10000;
    localparam logic [15:0]        VOTE_HALF = 16'h8000;
    localparam logic [15:0]        VOTE_MAX  = 16'hFFFF;
    localparam logic [STEP_W-1:0]  FOLD_STEPS = 6'd32;
    localparam logic [STEP_W-1:0]  VOTE_STEPS = 6'd16;

    typedef struct packed {
        logic clr;
        logic take;
        logic smp_wr;
        logic fold_rd;
        logic fold_mul;
        logic fold_scl;
        logic fold_wr;
        logic skl_mul;
        logic skl_add;
        logic vote_mul;
        logic vote_sel;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic addr_last;
        logic fold_req;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/fbh_in_if.sv -----
// ----------------------------------------------------------------------------
// fbh_in_if
// input item channel: training samples and vote queries
// ----------------------------------------------------------------------------
interface fbh_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [16:0] fg_weight;
    logic        last;
    logic [31:0] fg_area;
    logic [31:0] bg_area;

    modport source (output valid, kind, blue, green, red, fg_weight, last, fg_area,
                    bg_area, input ready);
    modport sink (input valid, kind, blue, green, red, fg_weight, last, fg_area,
                  bg_area, output ready);
endinterface

// ----- rtl/fbh_out_if.sv -----
// ----------------------------------------------------------------------------
// fbh_out_if
// result item channel: vote answers and batch fold reports
// ----------------------------------------------------------------------------
interface fbh_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] vote;
    logic        batch_done;
    logic [39:0] skill;

    modport source (output valid, vote, batch_done, skill, input ready);
    modport sink (input valid, vote, batch_done, skill, output ready);
endinterface

// ----- rtl/fbh_div.sv -----
// ----------------------------------------------------------------------------
// fbh_div
// restoring divider, one quotient bit per cycle, numerator below divisor
// ----------------------------------------------------------------------------
module fbh_div import fbh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_den,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_busy,
    output logic [QUO_W-1:0]  o_quo
);
    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W:0]    r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quo;
    logic [DIV_W:0]    rem2;
    logic              ge;

    assign rem2 = {r_rem[DIV_W-1:0], 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem2 - {1'b0, r_den} : rem2;
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// ----- rtl/fbh_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbh_ctrl
// sequencer for clearing, sample update, batch fold walk and vote
// ----------------------------------------------------------------------------
module fbh_ctrl import fbh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [15:0] {
        ST_CLR   = 16'h0001,
        ST_IDLE  = 16'h0002,
        ST_S_RD  = 16'h0004,
        ST_S_WR  = 16'h0008,
        ST_F_RD  = 16'h0010,
        ST_F_MUL = 16'h0020,
        ST_F_DIV = 16'h0040,
        ST_F_SCL = 16'h0080,
        ST_F_WR  = 16'h0100,
        ST_K_MUL = 16'h0200,
        ST_K_ADD = 16'h0400,
        ST_V_RD  = 16'h0800,
        ST_V_MUL = 16'h1000,
        ST_V_SEL = 16'h2000,
        ST_V_DIV = 16'h4000,
        ST_OUT   = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_in_kind ? ST_V_RD : ST_S_RD;
                end
            end
            ST_S_RD: n_state = ST_S_WR;
            ST_S_WR: begin
                o_cmd.smp_wr = 1'b1;
                n_state      = i_sts.fold_req ? ST_F_RD : ST_IDLE;
            end
            ST_F_RD: begin
                o_cmd.fold_rd = 1'b1;
                n_state       = ST_F_MUL;
            end
            ST_F_MUL: begin
                o_cmd.fold_mul = 1'b1;
                n_state        = ST_F_DIV;
            end
            ST_F_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_F_SCL;
                end
            end
            ST_F_SCL: begin
                o_cmd.fold_scl = 1'b1;
                n_state        = ST_F_WR;
            end
            ST_F_WR: begin
                o_cmd.fold_wr = 1'b1;
                n_state       = i_sts.addr_last ? ST_K_MUL : ST_F_RD;
            end
            ST_K_MUL: begin
                o_cmd.skl_mul = 1'b1;
                n_state       = ST_K_ADD;
            end
            ST_K_ADD: begin
                o_cmd.skl_add = 1'b1;
                n_state       = ST_OUT;
            end
            ST_V_RD: n_state = ST_V_MUL;
            ST_V_MUL: begin
                o_cmd.vote_mul = 1'b1;
                n_state        = ST_V_SEL;
            end
            ST_V_SEL: begin
                o_cmd.vote_sel = 1'b1;
                n_state        = ST_V_DIV;
            end
            ST_V_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_CLR;
        endcase
    end
endmodule

// ----- rtl/fbh_dp.sv -----
// ----------------------------------------------------------------------------
// fbh_dp
// histogram memories, batch accumulators, fold arithmetic, vote and result
// ----------------------------------------------------------------------------
module fbh_dp import fbh_pkg::*; #(
    parameter int BINS      = DEF_BINS,
    parameter int BIN_WIDTH = DEF_BIN_WIDTH,
    parameter int MAX_BATCH = DEF_MAX_BATCH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_kind,
    input  logic [7:0]            i_blue,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_red,
    input  logic [16:0]           i_fg_weight,
    input  logic                  i_last,
    input  logic [31:0]           i_fg_area,
    input  logic [31:0]           i_bg_area,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [15:0]           o_vote,
    output logic                  o_batch_done,
    output logic [SKILL_W-1:0]    o_skill
);
    localparam int NB    = BINS * BINS * BINS;
    localparam int AW    = $clog2(NB);
    localparam int CB_W  = $clog2(BINS);
    localparam int RECIP = (65536 + BIN_WIDTH - 1) / BIN_WIDTH;
    localparam int CNT_W = $clog2(MAX_BATCH + 1);
    localparam int ETA_W = CNT_W + 17;
    localparam logic [AW-1:0]    LAST_ADDR = AW'(NB - 1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_BATCH - 1);
    localparam logic [SKILL_W-1:0] SKILL_SAT = '1;

    function automatic logic [CB_W-1:0] chan_bin(input logic [7:0] c);
        logic [24:0] prod;
        logic [8:0]  q;
        prod = 25'(c) * 25'(RECIP);
        q    = prod[24:16];
        if (q > 9'(BINS - 1)) begin
            chan_bin = CB_W'(BINS - 1);
        end else begin
            chan_bin = q[CB_W-1:0];
        end
    endfunction

    // configuration and captured item
    logic [15:0] r_fg_rate, r_bg_rate;
    logic        r_kind, r_last, r_in_ratio;
    logic [7:0]  r_blue, r_green, r_red;
    logic [16:0] r_w;
    logic [31:0] r_ea, r_eb;

    // batch state
    logic [ETA_W-1:0]   r_sum, r_eta_b;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_trained;
    logic [SKILL_W-1:0] r_skill;
    logic [AW-1:0]      r_addr;

    // histogram memories
    logic [PROB_W-1:0] m_fp [NB];
    logic [PROB_W-1:0] m_bp [NB];
    logic [PROB_W-1:0] m_fq [NB];
    logic [PROB_W-1:0] m_bq [NB];
    logic [PROB_W-1:0] r_rd_fp, r_rd_bp, r_rd_fq, r_rd_bq;

    // arithmetic pipeline
    logic [48:0] r_dec_f, r_dec_b;
    logic        r_sat_f, r_sat_b, r_nz_f, r_nz_b;
    logic [31:0] r_shr_f, r_shr_b;
    logic [56:0] r_skp;
    logic [63:0] r_fm, r_bm;
    logic [15:0] r_vote;
    logic        r_vote_div;

    // result register
    logic               r_out_valid, r_out_done;
    logic [15:0]        r_out_vote;
    logic [SKILL_W-1:0] r_out_skill;

    logic [AW-1:0]  bin, ra, wa;
    logic [16:0]    w_in, one_m_fa, one_m_ba;
    logic [34:0]    ea5, eb5;
    logic [ETA_W-1:0] total;
    logic           pend_we, prob_we;
    logic [PROB_W-1:0] fq_wd, bq_wd, fp_wd, bp_wd;
    logic [32:0]    fq_sum, bq_sum;
    logic [33:0]    pf_sum, pb_sum;
    logic [31:0]    share_f, share_b;
    logic [47:0]    sc_f, sc_b;
    logic [41:0]    sk_sum;
    logic [63:0]    f_sel, b_sel, v_sum;
    logic           v_need, fs_start, bs_start;
    logic           div0_start, div0_busy, div1_busy;
    logic [DIV_W-1:0]  div0_num, div0_den;
    logic [STEP_W-1:0] div0_steps;
    logic [QUO_W-1:0]  quo0, quo1;

    assign bin = (AW'(chan_bin(r_blue)) * AW'(BINS) + AW'(chan_bin(r_green))) * AW'(BINS)
                 + AW'(chan_bin(r_red));
    assign ra  = i_cmd.fold_rd ? r_addr : bin;
    assign wa  = i_cmd.smp_wr ? bin : r_addr;

    assign w_in     = (i_fg_weight > W_ONE) ? W_ONE : i_fg_weight;
    assign ea5      = {3'b0, i_fg_area} + {1'b0, i_fg_area, 2'b0};
    assign eb5      = {3'b0, i_bg_area} + {1'b0, i_bg_area, 2'b0};
    assign one_m_fa = W_ONE - {1'b0, r_fg_rate};
    assign one_m_ba = W_ONE - {1'b0, r_bg_rate};
    assign total    = ETA_W'({r_cnt, 16'b0});

    // sample and fold write data
    assign fq_sum = {1'b0, r_rd_fq} + 33'(r_w);
    assign bq_sum = {1'b0, r_rd_bq} + 33'(W_ONE - r_w);
    assign pf_sum = 34'(r_dec_f[48:16]) + 34'(r_nz_f ? r_shr_f : 32'd0);
    assign pb_sum = 34'(r_dec_b[48:16]) + 34'(r_nz_b ? r_shr_b : 32'd0);

    assign pend_we = i_cmd.clr | i_cmd.smp_wr | i_cmd.fold_wr;
    assign prob_we = i_cmd.clr | i_cmd.fold_wr;

    always_comb begin
        fq_wd = '0;
        bq_wd = '0;
        fp_wd = '0;
        bp_wd = '0;
        if (i_cmd.smp_wr) begin
            fq_wd = fq_sum[32] ? '1 : fq_sum[31:0];
            bq_wd = bq_sum[32] ? '1 : bq_sum[31:0];
        end
        if (i_cmd.fold_wr) begin
            fp_wd = (pf_sum[33:32] != 2'b00) ? '1 : pf_sum[31:0];
            bp_wd = (pb_sum[33:32] != 2'b00) ? '1 : pb_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            m_fq[wa] <= fq_wd;
            m_bq[wa] <= bq_wd;
        end
        if (prob_we) begin
            m_fp[wa] <= fp_wd;
            m_bp[wa] <= bp_wd;
        end
        r_rd_fp <= m_fp[ra];
        r_rd_bp <= m_bp[ra];
        r_rd_fq <= m_fq[ra];
        r_rd_bq <= m_bq[ra];
    end

    // fold shares
    assign fs_start = (r_sum != '0) && (64'(r_rd_fq) < 64'(r_sum));
    assign bs_start = (r_eta_b != '0) && (64'(r_rd_bq) < 64'(r_eta_b));
    assign share_f  = r_sat_f ? '1 : quo0;
    assign share_b  = r_sat_b ? '1 : quo1;
    assign sc_f     = 48'(share_f) * 48'(r_fg_rate);
    assign sc_b     = 48'(share_b) * 48'(r_bg_rate);
    assign sk_sum   = 42'(r_skp[56:16]) + 42'({r_cnt, 8'b0});

    // vote terms
    assign f_sel  = r_in_ratio ? {2'b0, r_fm[63:2]} : 64'(r_rd_fp);
    assign b_sel  = r_in_ratio ? {2'b0, r_bm[63:2]} : 64'(r_rd_bp);
    assign v_sum  = f_sel + b_sel;
    assign v_need = (b_sel != '0);

    assign div0_start = (i_cmd.fold_mul & fs_start) | (i_cmd.vote_sel & v_need);
    assign div0_num   = i_cmd.vote_sel ? f_sel : 64'(r_rd_fq);
    assign div0_den   = i_cmd.vote_sel ? v_sum : 64'(r_sum);
    assign div0_steps = i_cmd.vote_sel ? VOTE_STEPS : FOLD_STEPS;

    fbh_div u_div_fg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div0_start),
        .i_num   (div0_num),
        .i_den   (div0_den),
        .i_steps (div0_steps),
        .o_busy  (div0_busy),
        .o_quo   (quo0)
    );

    fbh_div u_div_bg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.fold_mul & bs_start),
        .i_num   (64'(r_rd_bq)),
        .i_den   (64'(r_eta_b)),
        .i_steps (FOLD_STEPS),
        .o_busy  (div1_busy),
        .o_quo   (quo1)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_rate   <= FG_RATE_RST;
            r_bg_rate   <= BG_RATE_RST;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_trained   <= 1'b0;
            r_skill     <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FG_RATE: r_fg_rate <= i_cfg_data;
                    CFG_BG_RATE: r_bg_rate <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.smp_wr) begin
                r_sum <= r_sum + ETA_W'(r_w);
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.skl_add) begin
                r_skill   <= (sk_sum > 42'(SKILL_SAT)) ? SKILL_SAT : sk_sum[SKILL_W-1:0];
                r_sum     <= '0;
                r_cnt     <= '0;
                r_trained <= 1'b1;
            end
            if (i_cmd.clr | i_cmd.fold_wr) begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_eta_b <= (total > r_sum) ? total - r_sum : '0;
        if (i_cmd.take) begin
            r_kind     <= i_kind;
            r_blue     <= i_blue;
            r_green    <= i_green;
            r_red      <= i_red;
            r_w        <= w_in;
            r_last     <= i_last;
            r_ea       <= i_fg_area;
            r_eb       <= i_bg_area;
            r_in_ratio <= (eb5 >= {3'b0, i_fg_area}) && (ea5 >= {3'b0, i_bg_area});
        end
        if (i_cmd.fold_mul) begin
            r_dec_f <= 49'(r_rd_fp) * 49'(one_m_fa);
            r_dec_b <= 49'(r_rd_bp) * 49'(one_m_ba);
            r_nz_f  <= r_sum != '0;
            r_nz_b  <= r_eta_b != '0;
            r_sat_f <= 64'(r_rd_fq) >= 64'(r_sum);
            r_sat_b <= 64'(r_rd_bq) >= 64'(r_eta_b);
        end
        if (i_cmd.fold_scl) begin
            r_shr_f <= r_trained ? sc_f[47:16] : share_f;
            r_shr_b <= r_trained ? sc_b[47:16] : share_b;
        end
        if (i_cmd.skl_mul) begin
            r_skp <= 57'(r_skill) * 57'(one_m_fa);
        end
        if (i_cmd.vote_mul) begin
            r_fm <= 64'(r_ea) * 64'(r_rd_fp);
            r_bm <= 64'(r_eb) * 64'(r_rd_bp);
        end
        if (i_cmd.vote_sel) begin
            r_vote_div <= v_need;
            r_vote     <= (f_sel == '0 && b_sel == '0) ? VOTE_HALF : VOTE_MAX;
        end
        if (i_cmd.emit) begin
            r_out_vote  <= r_kind ? (r_vote_div ? quo0[15:0] : r_vote) : 16'd0;
            r_out_done  <= ~r_kind;
            r_out_skill <= r_skill;
        end
    end

    assign o_sts.addr_last = r_addr == LAST_ADDR;
    assign o_sts.fold_req  = r_last | (r_cnt == CNT_LAST);
    assign o_sts.div_busy  = div0_busy | div1_busy;
    assign o_sts.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_vote       = r_out_vote;
    assign o_batch_done = r_out_done;
    assign o_skill      = r_out_skill;
endmodule

// ----- rtl/fg_bg_color_histogram_vote.sv -----
// ----------------------------------------------------------------------------
// fg_bg_color_histogram_vote
// foreground/background colour histogram learner with posterior vote
// ----------------------------------------------------------------------------
// One item is handled at a time. A training sample is accepted, then the
// pending entries of its bin are read and written; the sample that closes
// a batch then walks all BINS^3 bins, where each bin is read, multiplied,
// waits on the bit-serial share dividers, is scaled and written, and then
// the block does the skill update and emits the result. A vote reads its
// bin, multiplies, selects and waits on the foreground share divider.
// After reset the block clears its four histogram memories, one bin per
// cycle, before it takes the first item; configuration writes are taken at
// any time. A finished result waits in an output register while the next
// item is accepted.
module fg_bg_color_histogram_vote import fbh_pkg::*; #(
    parameter int BINS_PER_CHANNEL = DEF_BINS,
    parameter int BIN_WIDTH        = DEF_BIN_WIDTH,
    parameter int MAX_BATCH        = DEF_MAX_BATCH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fbh_in_if.sink                i_smp,
    fbh_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_smp.ready = in_ready;

    fbh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_in_kind  (i_smp.kind),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fbh_dp #(
        .BINS      (BINS_PER_CHANNEL),
        .BIN_WIDTH (BIN_WIDTH),
        .MAX_BATCH (MAX_BATCH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_smp.kind),
        .i_blue       (i_smp.blue),
        .i_green      (i_smp.green),
        .i_red        (i_smp.red),
        .i_fg_weight  (i_smp.fg_weight),
        .i_last       (i_smp.last),
        .i_fg_area    (i_smp.fg_area),
        .i_bg_area    (i_smp.bg_area),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_vote       (o_res.vote),
        .o_batch_done (o_res.batch_done),
        .o_skill      (o_res.skill)
    );

`include "assert_macros.svh"

    `ASSERT_IMP(a_emit_free, i_clk, i_rst_n, cmd.emit, sts.out_free)
    `ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_smp.valid && i_smp.ready, !i_smp.ready)
    `ASSERT_NXT(a_walk_end, i_clk, i_rst_n, cmd.fold_wr && sts.addr_last, cmd.skl_mul)
endmodule
